// ----- hw/rtl/frasm_pkg.sv -----
// Fragment reassembler package: request and result payload types, widths,
// operation and status codes, and configuration register indexes.
// Used by the top level and the checker; frasm_ram stands alone.
`timescale 1ns / 1ps
`default_nettype none

package frasm_pkg;

    localparam int PACKET_BYTES_DEF     = 512;
    localparam int FRAME_DATA_BYTES_DEF = 127;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 32;
    localparam int INDEX_W  = 9;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 10;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int HDR_CONT_BIT     = 7;
    localparam int CLASS_SMALL_DATA = 64 - 1;
    localparam int CLASS_LARGE_DATA = 128 - 1;

    localparam logic [FILL_W-1:0] MAX_PACKET_RESET = 10'd500;
    localparam logic [TIME_W-1:0] TIMEOUT_RESET    = 32'd1000;

    localparam logic [OP_W-1:0] OP_FRAME = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SEQUENCE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PACKET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [BYTE_W-1:0]  byte_value;
        logic               frame_end;
        logic [TIME_W-1:0]  now_ms;
        logic [INDEX_W-1:0] read_index;
    } frag_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   pkt_length;
        logic [BYTE_W-1:0]   read_data;
    } frag_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/frasm_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stands alone; used for the frame stage and the packet store.
`timescale 1ns / 1ps
`default_nettype none

module frasm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/fragment_reassembler_top.sv -----
// Fragment reassembler top level: frame tracking, frame judging, stage-to-store
// copy and read-back. Depends on frasm_pkg and frasm_ram.
//
// Usage. Requests arrive on frag (valid/ready), one byte or command each.
// Op frame carries one frame byte; the first byte of a frame is its header.
// Op read returns one packet store byte; op clear drops the reassembly.
// Results leave on result (valid/ready) through a single output register.
// Flow. A frame byte without frame_end gives no result. At a frame end the
// judge state gives the result if the frame is not appended; else the copy
// state moves its len data bytes, one byte per cycle, from the frame stage
// read port into the packet store, and the finish state gives the result. A
// read takes the registered packet store read in the read state. Reset clears
// the reassembly and frame tracking and restores the configuration defaults;
// the stores need no clearing pass. While a result waits for result_ready,
// frag_ready stays low, so nothing is lost or overtaken. Configuration is to
// be written through cfg_we, cfg_index and cfg_data while idle (unchecked).
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembler_top #(
    parameter int PACKET_BYTES     = frasm_pkg::PACKET_BYTES_DEF,
    parameter int FRAME_DATA_BYTES = frasm_pkg::FRAME_DATA_BYTES_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                frag_valid,
    output logic                                     frag_ready,
    input  wire frasm_pkg::frag_req_t                frag,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output frasm_pkg::frag_res_t                     result,
    input  wire logic                                cfg_we,
    input  wire logic [frasm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [frasm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import frasm_pkg::*;

    localparam int PAW = (PACKET_BYTES > 1) ? $clog2(PACKET_BYTES) : 1;
    localparam int SAW = (FRAME_DATA_BYTES > 1) ? $clog2(FRAME_DATA_BYTES) : 1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_JUDGE  = 5'b00100,
        S_COPY   = 5'b01000,
        S_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic                  sel_reg, sel_next;
    logic [FILL_W-1:0]     max_reg, max_next;
    logic [TIME_W-1:0]     timeout_reg, timeout_next;

    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [LEN_W-1:0]      exp_reg, exp_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic                  inprog_reg, inprog_next;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [BYTE_W-1:0]     hdr_reg, hdr_next;
    logic                  too_long_reg, too_long_next;

    logic [TIME_W-1:0]     now_reg, now_next;
    logic                  oob_reg, oob_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic [FILL_W-1:0]     base_reg, base_next;
    logic                  wr_pend_reg, wr_pend_next;
    logic [PAW-1:0]        wr_addr_reg, wr_addr_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [FILL_W-1:0]     plen_reg, plen_next;

    logic                  res_valid_reg, res_valid_next;
    frag_res_t             res_reg, res_next;

    logic [FILL_W-1:0]     j_fill;
    logic [LEN_W-1:0]      j_exp;
    logic [TIME_W-1:0]     j_start;
    logic                  j_inprog;
    logic [STATUS_W-1:0]   j_status;
    logic                  j_copy;
    logic [FILL_W-1:0]     j_plen;
    logic [FILL_W-1:0]     j_base;
    logic [LEN_W-1:0]      j_len;

    logic                  stage_we;
    logic [SAW-1:0]        stage_waddr;
    logic                  stage_re;
    logic [BYTE_W-1:0]     stage_rdata;
    logic                  store_re;
    logic [BYTE_W-1:0]     store_rdata;
    logic                  accept;

    frasm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_DATA_BYTES)
    ) u_stage (
        .clk     (clk),
        .wr_en   (stage_we),
        .wr_addr (stage_waddr),
        .wr_data (frag.byte_value),
        .rd_en   (stage_re),
        .rd_addr (SAW'(cnt_reg)),
        .rd_data (stage_rdata)
    );

    frasm_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PACKET_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_pend_reg),
        .wr_addr (wr_addr_reg),
        .wr_data (stage_rdata),
        .rd_en   (store_re),
        .rd_addr (PAW'(frag.read_index)),
        .rd_data (store_rdata)
    );

    assign frag_ready   = (state_reg == S_IDLE) && (!res_valid_reg || result_ready);
    assign accept       = frag_valid && frag_ready;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Frame judgement, in the order invalid, timeout, sequence, overflow.
    always_comb
    begin
        logic [POS_W-1:0]  flen;
        logic [POS_W-1:0]  class_data;
        logic [TIME_W-1:0] age;
        logic              cont;
        logic [LEN_W-1:0]  rem;
        logic [FILL_W-1:0] lim;
        logic              done;

        flen       = pos_reg - POS_W'(1);
        class_data = sel_reg ? POS_W'(CLASS_LARGE_DATA) : POS_W'(CLASS_SMALL_DATA);
        age        = now_reg - start_reg;
        cont       = hdr_reg[HDR_CONT_BIT];
        rem        = hdr_reg[LEN_W-1:0];
        lim        = (32'(max_reg) > PACKET_BYTES) ? FILL_W'(PACKET_BYTES) : max_reg;
        done       = 1'b0;

        j_fill   = fill_reg;
        j_exp    = exp_reg;
        j_start  = start_reg;
        j_inprog = inprog_reg;
        j_status = ST_INVALID;
        j_copy   = 1'b0;
        j_plen   = '0;
        j_base   = fill_reg;
        j_len    = flen[LEN_W-1:0];

        if (pos_reg == '0 || flen == '0 || too_long_reg || flen > class_data)
        begin
            done = 1'b1;
        end

        if (!done && inprog_reg && age > timeout_reg)
        begin
            j_fill   = '0;
            j_exp    = '0;
            j_start  = '0;
            j_inprog = 1'b0;
            if (cont)
            begin
                j_status = ST_TIMEOUT;
                done     = 1'b1;
            end
        end

        if (!done)
        begin
            if (!cont)
            begin
                j_fill   = '0;
                j_inprog = 1'b1;
                j_exp    = rem;
                j_start  = now_reg;
            end
            else if (!j_inprog || j_exp == '0 ||
                     ({1'b0, rem} + POS_W'(1)) != {1'b0, j_exp})
            begin
                j_fill   = '0;
                j_exp    = '0;
                j_start  = '0;
                j_inprog = 1'b0;
                j_status = ST_SEQUENCE;
                done     = 1'b1;
            end
            else
            begin
                j_exp = rem;
            end
        end

        if (!done)
        begin
            if ((11'(j_fill) + 11'(flen)) > 11'(lim))
            begin
                j_fill   = '0;
                j_exp    = '0;
                j_start  = '0;
                j_inprog = 1'b0;
                j_status = ST_OVERFLOW;
            end
            else
            begin
                j_copy = 1'b1;
                j_base = j_fill;
                j_fill = j_fill + FILL_W'(flen);
                if (j_exp == '0)
                begin
                    j_status = ST_OK;
                    j_plen   = j_fill;
                    j_inprog = 1'b0;
                end
                else
                begin
                    j_status = ST_INCOMPLETE;
                end
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        max_next      = max_reg;
        timeout_next  = timeout_reg;
        fill_next     = fill_reg;
        exp_next      = exp_reg;
        start_next    = start_reg;
        inprog_next   = inprog_reg;
        pos_next      = pos_reg;
        hdr_next      = hdr_reg;
        too_long_next = too_long_reg;
        now_next      = now_reg;
        oob_next      = oob_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        base_next     = base_reg;
        wr_pend_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        status_next   = status_reg;
        plen_next     = plen_reg;
        res_valid_next = res_valid_reg && !result_ready;
        res_next      = res_reg;
        stage_we      = 1'b0;
        stage_waddr   = SAW'(pos_reg - POS_W'(1));
        stage_re      = 1'b0;
        store_re      = 1'b0;

        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAYLOAD_SEL: sel_next     = cfg_data[0];
                CFG_MAX_PACKET:  max_next     = cfg_data[FILL_W-1:0];
                CFG_TIMEOUT:     timeout_next = cfg_data[TIME_W-1:0];
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (frag.op)
                        OP_FRAME:
                        begin
                            if (pos_reg == '0)
                            begin
                                hdr_next = frag.byte_value;
                                pos_next = POS_W'(1);
                            end
                            else if (32'(pos_reg) <= FRAME_DATA_BYTES)
                            begin
                                stage_we = 1'b1;
                                pos_next = pos_reg + POS_W'(1);
                            end
                            else
                            begin
                                too_long_next = 1'b1;
                            end
                            if (frag.frame_end)
                            begin
                                now_next   = frag.now_ms;
                                state_next = S_JUDGE;
                            end
                        end
                        OP_READ:
                        begin
                            store_re   = 1'b1;
                            oob_next   = !(32'(frag.read_index) < PACKET_BYTES);
                            state_next = S_READ;
                        end
                        OP_CLEAR:
                        begin
                            fill_next     = '0;
                            exp_next      = '0;
                            start_next    = '0;
                            inprog_next   = 1'b0;
                            pos_next      = '0;
                            hdr_next      = '0;
                            too_long_next = 1'b0;
                        end
                        OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_valid_next         = 1'b1;
                res_next.status        = ST_OK;
                res_next.pkt_length    = '0;
                res_next.read_data     = oob_reg ? '0 : store_rdata;
                state_next             = S_IDLE;
            end
            S_JUDGE:
            begin
                fill_next     = j_fill;
                exp_next      = j_exp;
                start_next    = j_start;
                inprog_next   = j_inprog;
                pos_next      = '0;
                hdr_next      = '0;
                too_long_next = 1'b0;
                status_next   = j_status;
                plen_next     = j_plen;
                len_next      = j_len;
                base_next     = j_base;
                cnt_next      = '0;
                if (j_copy)
                begin
                    state_next = S_COPY;
                end
                else
                begin
                    res_valid_next         = 1'b1;
                    res_next.status        = j_status;
                    res_next.pkt_length    = j_plen;
                    res_next.read_data     = '0;
                    state_next             = S_IDLE;
                end
            end
            S_COPY:
            begin
                stage_re     = 1'b1;
                wr_pend_next = 1'b1;
                wr_addr_next = PAW'(11'(base_reg) + 11'(cnt_reg));
                cnt_next     = cnt_reg + LEN_W'(1);
                if (cnt_reg == len_reg - LEN_W'(1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                res_valid_next         = 1'b1;
                res_next.status        = status_reg;
                res_next.pkt_length    = plen_reg;
                res_next.read_data     = '0;
                state_next             = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= 1'b0;
            max_reg       <= MAX_PACKET_RESET;
            timeout_reg   <= TIMEOUT_RESET;
            fill_reg      <= '0;
            exp_reg       <= '0;
            start_reg     <= '0;
            inprog_reg    <= 1'b0;
            pos_reg       <= '0;
            hdr_reg       <= '0;
            too_long_reg  <= 1'b0;
            wr_pend_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            max_reg       <= max_next;
            timeout_reg   <= timeout_next;
            fill_reg      <= fill_next;
            exp_reg       <= exp_next;
            start_reg     <= start_next;
            inprog_reg    <= inprog_next;
            pos_reg       <= pos_next;
            hdr_reg       <= hdr_next;
            too_long_reg  <= too_long_next;
            wr_pend_reg   <= wr_pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        oob_reg     <= oob_next;
        len_reg     <= len_next;
        cnt_reg     <= cnt_next;
        base_reg    <= base_next;
        wr_addr_reg <= wr_addr_next;
        status_reg  <= status_next;
        plen_reg    <= plen_next;
        res_reg     <= res_next;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/frasm_checker.sv -----
// Port-level checker for the fragment reassembler, bound to the top level.
// Depends on frasm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module frasm_checker (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    frag_valid,
    input wire logic                    frag_ready,
    input wire frasm_pkg::frag_req_t    frag,
    input wire logic                    result_valid,
    input wire logic                    result_ready,
    input wire frasm_pkg::frag_res_t    result
);

    import frasm_pkg::*;

    logic accept;

    assign accept = frag_valid && frag_ready;

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

    // No request is taken while a result waits to be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !frag_ready)
    else $error("request taken while result stalled");

    // A read request answers, by way of the read state and the result register, with status ok and no length.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && frag.op == OP_READ |-> ##2 result_valid &&
            result.status == ST_OK && result.pkt_length == '0)
    else $error("read request did not answer as expected");

    // A frame byte that does not end its frame leaves no result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && frag.op == OP_FRAME && !frag.frame_end |=> !result_valid)
    else $error("result appeared after a mid-frame byte");

    // Only a completed packet reports a length.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status == ST_OK || result.pkt_length == '0)
    else $error("packet length on a non-ok status");

endmodule

bind fragment_reassembler_top frasm_checker u_frasm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .frag_valid   (frag_valid),
    .frag_ready   (frag_ready),
    .frag         (frag),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire
